// ----- rtl/core/bpe_pkg.sv -----
// Shared types, constants and helpers of the byte-pair token encoder.
package bpe_pkg;

  localparam int unsigned MAX_RULES    = 4096;
  localparam int unsigned MAX_WORD_LEN = 32;

  localparam int unsigned TOK_W       = 12;
  localparam int unsigned CFG_W       = 13;
  localparam int unsigned OP_W        = 3;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned RULE_ADDR_W = $clog2(MAX_RULES);
  localparam int unsigned RCNT_W      = $clog2(MAX_RULES + 1);
  localparam int unsigned IDX_W       = $clog2(MAX_WORD_LEN);
  localparam int unsigned LEN_W       = $clog2(MAX_WORD_LEN + 1);
  localparam int unsigned RULE_W      = 3 * TOK_W;

  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_MAP_LOAD  = 3'd0;
  localparam logic [OP_W-1:0] OP_RULE_LOAD = 3'd1;
  localparam logic [OP_W-1:0] OP_START     = 3'd2;
  localparam logic [OP_W-1:0] OP_TEXT      = 3'd3;
  localparam logic [OP_W-1:0] OP_END       = 3'd4;

  // Fixed tokens
  localparam logic [TOK_W-1:0] TOK_END     = 12'd1;
  localparam logic [TOK_W-1:0] TOK_BEGIN   = 12'd2;
  localparam logic [TOK_W-1:0] TOK_UNKNOWN = 12'd3;

  typedef struct packed {
    logic [TOK_W-1:0]  merged_id;
    logic [TOK_W-1:0]  right_id;
    logic [TOK_W-1:0]  left_id;
    logic [TOK_W-1:0]  rule_index;
    logic [TOK_W-1:0]  token_id;
    logic              byte_known;
    logic [BYTE_W-1:0] byte_value;
  } item_t;

  typedef struct packed {
    logic [TOK_W-1:0] merged_id;
    logic [TOK_W-1:0] right_id;
    logic [TOK_W-1:0] left_id;
  } rule_t;

  // Controller to datapath
  typedef struct packed {
    logic                   map_wr;
    logic                   rule_wr;
    logic                   byte_capture;
    logic                   len_clear;
    logic                   append;
    logic                   rule_rd;
    logic [RULE_ADDR_W-1:0] rule_addr;
    logic                   rule_latch;
    logic                   merge_init;
    logic                   merge_step;
    logic                   merge_commit;
    logic                   emit_word;
    logic                   emit_const;
    logic [TOK_W-1:0]       const_tok;
    logic                   out_last;
    logic                   out_ovf;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic len_zero;
    logic len_one;
    logic len_full;
    logic class_change;
    logic pair_found;
    logic merge_done;
    logic out_free;
  } sts_t;

  function automatic logic is_space(input logic [BYTE_W-1:0] b);
    is_space = (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) ||
               (b == 8'h0D) || (b == 8'h0C) || (b == 8'h0B);
  endfunction

endpackage

// ----- rtl/core/bpe_ram.sv -----
// Generic simple dual-port RAM with registered read.
module bpe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/bpe_datapath.sv -----
// Datapath: byte map, rule table, word buffer, merge pass and output register.
module bpe_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bpe_pkg::item_t                  item_i,
  input  bpe_pkg::cmd_t                   cmd_i,
  output bpe_pkg::sts_t                   sts_o,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [bpe_pkg::TOK_W-1:0]       out_token_o,
  output logic                            out_last_o,
  output logic                            out_ovf_o
);

  localparam int unsigned N = bpe_pkg::MAX_WORD_LEN;

  logic [255:0]                      map_valid_q;
  logic                              mv_q;
  logic                              ws_q;
  logic                              space_q;
  logic [bpe_pkg::LEN_W-1:0]         len_q;
  logic [bpe_pkg::LEN_W-1:0]         srem_q;
  logic [bpe_pkg::LEN_W-1:0]         j_q;
  logic [bpe_pkg::TOK_W-1:0]         s_q [N];
  logic [bpe_pkg::TOK_W-1:0]         d_q [N];
  bpe_pkg::rule_t                    rule_q;
  logic                              out_valid_q;
  logic [bpe_pkg::TOK_W-1:0]         out_tok_q;
  logic                              out_last_q;
  logic                              out_ovf_q;

  logic [bpe_pkg::TOK_W-1:0]         map_rdata;
  logic [bpe_pkg::RULE_W-1:0]        rule_rdata;
  bpe_pkg::rule_t                    rule_rd;
  logic [bpe_pkg::TOK_W-1:0]         byte_tok;
  logic [N-2:0]                      pair_hit;
  logic                              head_match;
  logic                              rule_in_range;

  assign rule_in_range = 32'(item_i.rule_index) < bpe_pkg::MAX_RULES;

  bpe_ram #(.WIDTH(bpe_pkg::TOK_W), .DEPTH(256)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.map_wr),
    .waddr_i (item_i.byte_value),
    .wdata_i (item_i.token_id),
    .re_i    (cmd_i.byte_capture),
    .raddr_i (item_i.byte_value),
    .rdata_o (map_rdata)
  );

  bpe_ram #(.WIDTH(bpe_pkg::RULE_W), .DEPTH(bpe_pkg::MAX_RULES)) u_rule_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.rule_wr && rule_in_range),
    .waddr_i (item_i.rule_index[bpe_pkg::RULE_ADDR_W-1:0]),
    .wdata_i ({item_i.merged_id, item_i.right_id, item_i.left_id}),
    .re_i    (cmd_i.rule_rd),
    .raddr_i (cmd_i.rule_addr),
    .rdata_o (rule_rdata)
  );

  assign rule_rd  = bpe_pkg::rule_t'(rule_rdata);
  assign byte_tok = mv_q ? map_rdata : bpe_pkg::TOK_UNKNOWN;

  // Parallel pair compare against the freshly read rule
  always_comb begin
    for (int i = 0; i < N - 1; i++) begin
      pair_hit[i] = (s_q[i] == rule_rd.left_id) && (s_q[i+1] == rule_rd.right_id) &&
                    (32'(len_q) >= 32'(i + 2));
    end
  end

  assign head_match = (srem_q >= bpe_pkg::LEN_W'(2)) && (s_q[0] == rule_q.left_id) &&
                      (s_q[1] == rule_q.right_id);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_valid_q <= '0;
      len_q       <= '0;
      space_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.map_wr) begin
        map_valid_q[item_i.byte_value] <= item_i.byte_known;
      end
      if (cmd_i.len_clear) begin
        len_q <= '0;
      end else if (cmd_i.append) begin
        len_q <= len_q + bpe_pkg::LEN_W'(1);
        if (len_q == '0) begin
          space_q <= ws_q;
        end
      end else if (cmd_i.merge_commit) begin
        len_q <= j_q;
      end else if (cmd_i.emit_word && sts_o.out_free) begin
        len_q <= len_q - bpe_pkg::LEN_W'(1);
      end
      if (cmd_i.emit_word || cmd_i.emit_const) begin
        if (sts_o.out_free) begin
          out_valid_q <= 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.byte_capture) begin
      mv_q <= map_valid_q[item_i.byte_value];
      ws_q <= bpe_pkg::is_space(item_i.byte_value);
    end
    if (cmd_i.rule_latch) begin
      rule_q <= rule_rd;
    end
    if (cmd_i.merge_init) begin
      srem_q <= len_q;
      j_q    <= '0;
    end else if (cmd_i.merge_step) begin
      d_q[j_q[bpe_pkg::IDX_W-1:0]] <= head_match ? rule_q.merged_id : s_q[0];
      j_q    <= j_q + bpe_pkg::LEN_W'(1);
      srem_q <= srem_q - (head_match ? bpe_pkg::LEN_W'(2) : bpe_pkg::LEN_W'(1));
    end
    if (cmd_i.merge_commit) begin
      for (int i = 0; i < N; i++) begin
        s_q[i] <= d_q[i];
      end
    end else if (cmd_i.merge_step && head_match) begin
      for (int i = 0; i < N - 2; i++) begin
        s_q[i] <= s_q[i+2];
      end
    end else if (cmd_i.merge_step || (cmd_i.emit_word && sts_o.out_free)) begin
      for (int i = 0; i < N - 1; i++) begin
        s_q[i] <= s_q[i+1];
      end
    end else if (cmd_i.append) begin
      s_q[len_q[bpe_pkg::IDX_W-1:0]] <= byte_tok;
    end
    if (sts_o.out_free && (cmd_i.emit_word || cmd_i.emit_const)) begin
      out_tok_q  <= cmd_i.emit_word ? s_q[0] : cmd_i.const_tok;
      out_last_q <= cmd_i.out_last;
      out_ovf_q  <= cmd_i.out_ovf;
    end
  end

  always_comb begin
    sts_o.len_zero     = (len_q == '0);
    sts_o.len_one      = (len_q == bpe_pkg::LEN_W'(1));
    sts_o.len_full     = (32'(len_q) >= N);
    sts_o.class_change = (ws_q != space_q);
    sts_o.pair_found   = |pair_hit;
    sts_o.merge_done   = (srem_q == '0);
    sts_o.out_free     = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_token_o = out_tok_q;
  assign out_last_o  = out_last_q;
  assign out_ovf_o   = out_ovf_q;

endmodule

// ----- rtl/core/bpe_ctrl.sv -----
// Controller: sequences item handling, rule search, merge passes and emission.
module bpe_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [bpe_pkg::OP_W-1:0]    op_i,
  input  logic [bpe_pkg::CFG_W-1:0]   rule_count_i,
  input  bpe_pkg::sts_t               sts_i,
  output bpe_pkg::cmd_t               cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_BYTE   = 3'd1;
  localparam logic [2:0] ST_RADDR  = 3'd2;
  localparam logic [2:0] ST_RCMP   = 3'd3;
  localparam logic [2:0] ST_MERGE  = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;
  localparam logic [2:0] ST_END    = 3'd6;
  localparam logic [2:0] ST_BEGIN  = 3'd7;

  logic [2:0]                  state_q, state_d;
  logic [bpe_pkg::RCNT_W-1:0]  r_q, r_d;
  logic                        after_byte_q, after_byte_d;
  logic                        ovf_q, ovf_d;
  logic                        accept;
  logic                        rules_done;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign rules_done = (32'(r_q) >= 32'(rule_count_i)) || (32'(r_q) >= bpe_pkg::MAX_RULES);

  always_comb begin
    state_d      = state_q;
    r_d          = r_q;
    after_byte_d = after_byte_q;
    ovf_d        = ovf_q;
    cmd_o        = '0;
    cmd_o.rule_addr = r_q[bpe_pkg::RULE_ADDR_W-1:0];
    cmd_o.out_ovf   = ovf_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_i)
            bpe_pkg::OP_MAP_LOAD:  cmd_o.map_wr = 1'b1;
            bpe_pkg::OP_RULE_LOAD: cmd_o.rule_wr = 1'b1;
            bpe_pkg::OP_START: begin
              cmd_o.len_clear = 1'b1;
              state_d = ST_BEGIN;
            end
            bpe_pkg::OP_TEXT: begin
              cmd_o.byte_capture = 1'b1;
              state_d = ST_BYTE;
            end
            bpe_pkg::OP_END: begin
              after_byte_d = 1'b0;
              ovf_d        = 1'b0;
              r_d          = '0;
              state_d      = sts_i.len_zero ? ST_END : ST_RADDR;
            end
            default: ;
          endcase
        end
      end
      ST_BYTE: begin
        after_byte_d = 1'b1;
        r_d          = '0;
        if (!sts_i.len_zero && sts_i.class_change) begin
          ovf_d   = 1'b0;
          state_d = ST_RADDR;
        end else if (sts_i.len_full) begin
          ovf_d   = 1'b1;
          state_d = ST_RADDR;
        end else begin
          cmd_o.append = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_RADDR: begin
        if (sts_i.len_zero || sts_i.len_one || rules_done) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.rule_rd = 1'b1;
          state_d       = ST_RCMP;
        end
      end
      ST_RCMP: begin
        cmd_o.rule_latch = 1'b1;
        if (sts_i.pair_found) begin
          cmd_o.merge_init = 1'b1;
          state_d          = ST_MERGE;
        end else begin
          r_d     = r_q + bpe_pkg::RCNT_W'(1);
          state_d = ST_RADDR;
        end
      end
      ST_MERGE: begin
        if (sts_i.merge_done) begin
          cmd_o.merge_commit = 1'b1;
          r_d                = '0;
          state_d            = ST_RADDR;
        end else begin
          cmd_o.merge_step = 1'b1;
        end
      end
      ST_EMIT: begin
        if (sts_i.len_zero) begin
          if (after_byte_q) begin
            cmd_o.append = 1'b1;
            state_d      = ST_IDLE;
          end else begin
            state_d = ST_END;
          end
        end else begin
          cmd_o.emit_word = 1'b1;
          cmd_o.out_last  = after_byte_q && sts_i.len_one;
        end
      end
      ST_END, ST_BEGIN: begin
        cmd_o.emit_const = 1'b1;
        cmd_o.const_tok  = (state_q == ST_END) ? bpe_pkg::TOK_END : bpe_pkg::TOK_BEGIN;
        cmd_o.out_last   = 1'b1;
        cmd_o.out_ovf    = 1'b0;
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      r_q          <= '0;
      after_byte_q <= 1'b0;
      ovf_q        <= 1'b0;
    end else begin
      state_q      <= state_d;
      r_q          <= r_d;
      after_byte_q <= after_byte_d;
      ovf_q        <= ovf_d;
    end
  end

endmodule

// ----- rtl/core/bpe_token_encoder_core.sv -----
// Top level of the byte-pair token encoder: ports, config register, wiring.
//
//  Channel  | Direction | Handshake            | Payload
//  ---------+-----------+----------------------+--------------------------------------
//  s_axis   | in        | tvalid / tready      | tuser: operation; tdata: load/text fields
//  m_axis   | out       | tvalid / tready      | tdata: token; tlast: last_of_run;
//           |           |                      | tuser: word_overflow
//  cfg      | in        | valid / ready        | rule_count (13 bit)
//
// Steps: a load item is a single write; a start clears the run and emits the begin
//   token; a text byte without a flush is captured, then appended. A flush scans rule
//   ranks in order (rule memory read, then a parallel pair compare over the word
//   buffer), restarting at rank 0 after each merge pass over the tokens it leaves,
//   then emits each token and closes the run; the rule scan dominates.
// Reset clears the byte map valid bits, run length, class and rule_count at once.
// One transaction is worked at a time; a full output register stalls emission
//   and holds the result until m_axis_tready_i.
module bpe_token_encoder_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // byte_value[7:0], byte_known[8], token_id[20:9], rule_index[32:21],
  // left_id[44:33], right_id[56:45], merged_id[68:57], zero pad
  input  logic [bpe_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // operation[2:0]
  input  logic [bpe_pkg::OP_W-1:0]          s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // out_token[11:0], zero pad
  output logic [bpe_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  output logic                              m_axis_tlast_o,
  // word_overflow[0]
  output logic                              m_axis_tuser_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bpe_pkg::CFG_W-1:0]         cfg_data_i
);

  logic [bpe_pkg::CFG_W-1:0] rule_count_q;
  bpe_pkg::item_t            item;
  bpe_pkg::cmd_t             cmd;
  bpe_pkg::sts_t             sts;
  logic [bpe_pkg::TOK_W-1:0] out_token;

  // Config is to be written by the user only while idle; the block does not enforce it, so always take it
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_count_q <= '0;
    end else if (cfg_valid_i) begin
      rule_count_q <= cfg_data_i;
    end
  end

  // Unpack the transaction; drop the pad bits
  assign item = bpe_pkg::item_t'(s_axis_tdata_i[$bits(bpe_pkg::item_t)-1:0]);

  bpe_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .op_i         (s_axis_tuser_i),
    .rule_count_i (rule_count_q),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  bpe_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_token_o (out_token),
    .out_last_o  (m_axis_tlast_o),
    .out_ovf_o   (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = bpe_pkg::OUT_TDATA_W'(out_token);

endmodule
